### rtl/ksg_pkg.sv
// kinetic scroll gesture package: item types, event codes and register indexes
package ksg_pkg;

	// field widths
	localparam int POS_W   = 16;
	localparam int OFF_W   = 24;
	localparam int TIME_W  = 32;
	localparam int VEL_W   = 18;
	localparam int THR_W   = 10;
	localparam int IVL_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// event codes
	localparam logic [1:0] MODE_PRESS   = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_MOVE    = 2'd2;
	localparam logic [1:0] MODE_TICK    = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DRAG_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_INTERVAL    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK_FORWARD_EN  = 2'd2;

	// configuration reset values
	localparam logic [THR_W-1:0] DRAG_THRESHOLD_RST = 10'd10;
	localparam logic [IVL_W-1:0] SPEED_INTERVAL_RST = 16'd100;

	// input item
	typedef struct packed {
		logic [1:0]               mode;
		logic                     left_button;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [OFF_W-1:0]  cur_off_x;
		logic signed [OFF_W-1:0]  cur_off_y;
		logic [TIME_W-1:0]        now_ms;
	} ksg_in_t;

	// result item
	typedef struct packed {
		logic                     accepted;
		logic                     set_offset_valid;
		logic signed [OFF_W-1:0]  new_off_x;
		logic signed [OFF_W-1:0]  new_off_y;
		logic                     replay_click;
		logic signed [POS_W-1:0]  click_x;
		logic signed [POS_W-1:0]  click_y;
		logic                     ticker_run;
		logic [2:0]               gesture_state;
	} ksg_out_t;

endpackage

### rtl/kinetic_scroll_gesture_fsm.sv
// kinetic scroll gesture machine: input register, per-event update, result register
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in      | input     | in_valid / in_stall  | in_item  (ksg_in_t)
//  out     | output    | out_valid / out_stall| out_item (ksg_out_t)
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle while out_stall is low; an accepted item passes the input register, then
// the gesture update into the result register, which drives out_item.
// The gesture state is read and written in the update cycle only, so items follow
// back to back.
// arst_n clears the state machine, the gesture state, the configuration registers and
// the valid flags to their reset values; the item payloads are not reset; no clearing pass.
// out_stall holds the result register; the input register keeps taking one more item,
// then in_stall rises until the result is taken. cfg_ready is always high.
module kinetic_scroll_gesture_fsm
	import ksg_pkg::*;
#(
	parameter int MAX_SPEED = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ksg_in_t               in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ksg_out_t              out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_STEADY  = 3'd0,
		ST_PRESSED = 3'd1,
		ST_MANUAL  = 3'd2,
		ST_AUTO    = 3'd3,
		ST_STOP    = 3'd4
	} phase_t;

	localparam logic signed [VEL_W-1:0] SPEED_CAP = VEL_W'(MAX_SPEED);
	localparam logic signed [VEL_W-1:0] VEL_MAX   = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic signed [VEL_W-1:0] VEL_MIN   = {1'b1, {(VEL_W-1){1'b0}}};

	// saturate a difference one bit wider than the speed to the speed range
	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_W:0] d);
		logic signed [VEL_W-1:0] r;
		if (d[VEL_W] != d[VEL_W-1]) begin
			r = d[VEL_W] ? VEL_MIN : VEL_MAX;
		end else begin
			r = d[VEL_W-1:0];
		end
		return r;
	endfunction

	// clamp to the speed cap, then step one toward zero
	function automatic logic signed [VEL_W-1:0] decay(input logic signed [VEL_W-1:0] v);
		logic signed [VEL_W-1:0] c;
		logic signed [VEL_W-1:0] r;
		c = v;
		if (c > SPEED_CAP) begin
			c = SPEED_CAP;
		end
		if (c < -SPEED_CAP) begin
			c = -SPEED_CAP;
		end
		if (c > 0) begin
			r = c - VEL_W'(1);
		end else if (c < 0) begin
			r = c + VEL_W'(1);
		end else begin
			r = '0;
		end
		return r;
	endfunction

	// divide by four, truncating toward zero
	function automatic logic signed [VEL_W-1:0] div4(input logic signed [VEL_W-1:0] v);
		logic signed [VEL_W-1:0] a;
		a = v + (v[VEL_W-1] ? VEL_W'(3) : VEL_W'(0));
		return a >>> 2;
	endfunction

	// configuration registers
	logic [THR_W-1:0] drag_threshold_q;
	logic [IVL_W-1:0] speed_interval_q;
	logic             click_fwd_en_q;

	// input register
	logic    in_valid_s1;
	ksg_in_t in_item_s1;

	// gesture state
	phase_t                   phase_q;
	logic signed [POS_W-1:0]  press_x_q, press_y_q;
	logic signed [OFF_W-1:0]  base_x_q, base_y_q;
	logic signed [VEL_W-1:0]  last_x_q, last_y_q;
	logic signed [VEL_W-1:0]  vel_x_q, vel_y_q;
	logic [TIME_W-1:0]        stamp_q;

	// result register
	logic     out_valid_q;
	ksg_out_t out_item_q;

	// next values
	phase_t                   phase_d;
	logic signed [POS_W-1:0]  press_x_d, press_y_d;
	logic signed [OFF_W-1:0]  base_x_d, base_y_d;
	logic signed [VEL_W-1:0]  last_x_d, last_y_d;
	logic signed [VEL_W-1:0]  vel_x_d, vel_y_d;
	logic [TIME_W-1:0]        stamp_d;
	ksg_out_t                 res_d;

	// datapath terms
	logic                     advance;
	logic signed [POS_W:0]    dx, dy;
	logic signed [VEL_W-1:0]  thr_p, thr_n, dx_w, dy_w;
	logic                     beyond;
	logic [TIME_W-1:0]        elapsed;
	logic                     take_smp;
	logic signed [VEL_W-1:0]  smp_vx, smp_vy;
	logic signed [VEL_W-1:0]  dec_vx, dec_vy;
	logic signed [OFF_W-1:0]  drag_nx, drag_ny, tick_nx, tick_ny;

	// handshake
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = in_valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_threshold_q <= DRAG_THRESHOLD_RST;
			speed_interval_q <= SPEED_INTERVAL_RST;
			click_fwd_en_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DRAG_THRESHOLD:   drag_threshold_q <= cfg_data[THR_W-1:0];
				CFG_SPEED_INTERVAL:   speed_interval_q <= cfg_data[IVL_W-1:0];
				CFG_CLICK_FORWARD_EN: click_fwd_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_item_s1 <= in_item;
		end
	end

	// drag distance, threshold test and sample timing
	always_comb begin
		dx      = {in_item_s1.pos_x[POS_W-1], in_item_s1.pos_x} - {press_x_q[POS_W-1], press_x_q};
		dy      = {in_item_s1.pos_y[POS_W-1], in_item_s1.pos_y} - {press_y_q[POS_W-1], press_y_q};
		dx_w    = VEL_W'(dx);
		dy_w    = VEL_W'(dy);
		thr_p   = VEL_W'(drag_threshold_q);
		thr_n   = -thr_p;
		beyond  = (dx_w > thr_p) || (dx_w < thr_n) || (dy_w > thr_p) || (dy_w < thr_n);
		elapsed = in_item_s1.now_ms - stamp_q;
		take_smp = elapsed > TIME_W'(speed_interval_q);
		smp_vx  = sat_vel({dx_w[VEL_W-1], dx_w} - {last_x_q[VEL_W-1], last_x_q});
		smp_vy  = sat_vel({dy_w[VEL_W-1], dy_w} - {last_y_q[VEL_W-1], last_y_q});
		dec_vx  = decay(vel_x_q);
		dec_vy  = decay(vel_y_q);
		drag_nx = base_x_q - OFF_W'(dx);
		drag_ny = base_y_q - OFF_W'(dy);
		tick_nx = base_x_q - OFF_W'(dec_vx);
		tick_ny = base_y_q - OFF_W'(dec_vy);
	end

	// gesture transitions for the item in the input register
	always_comb begin
		phase_d   = phase_q;
		press_x_d = press_x_q;
		press_y_d = press_y_q;
		base_x_d  = base_x_q;
		base_y_d  = base_y_q;
		last_x_d  = last_x_q;
		last_y_d  = last_y_q;
		vel_x_d   = vel_x_q;
		vel_y_d   = vel_y_q;
		stamp_d   = stamp_q;
		res_d     = '0;

		case (in_item_s1.mode)
			MODE_PRESS: begin
				if (in_item_s1.left_button &&
				    (phase_q == ST_STEADY || phase_q == ST_AUTO)) begin
					res_d.accepted = 1'b1;
					press_x_d = in_item_s1.pos_x;
					press_y_d = in_item_s1.pos_y;
					base_x_d  = in_item_s1.cur_off_x;
					base_y_d  = in_item_s1.cur_off_y;
					if (phase_q == ST_STEADY) begin
						phase_d = ST_PRESSED;
					end else begin
						phase_d = ST_STOP;
						vel_x_d = '0;
						vel_y_d = '0;
					end
				end
			end
			MODE_RELEASE: begin
				if (in_item_s1.left_button) begin
					case (phase_q)
						ST_PRESSED: begin
							res_d.accepted = 1'b1;
							phase_d = ST_STEADY;
							if (click_fwd_en_q) begin
								res_d.replay_click = 1'b1;
								res_d.click_x = press_x_q;
								res_d.click_y = press_y_q;
							end
						end
						ST_MANUAL: begin
							res_d.accepted = 1'b1;
							base_x_d  = in_item_s1.cur_off_x;
							base_y_d  = in_item_s1.cur_off_y;
							press_x_d = in_item_s1.pos_x;
							press_y_d = in_item_s1.pos_y;
							if (take_smp) begin
								stamp_d  = in_item_s1.now_ms;
								last_x_d = dx_w;
								last_y_d = dy_w;
								vel_x_d  = smp_vx;
								vel_y_d  = smp_vy;
							end
							// launch auto scroll unless the speed is zero
							if (vel_x_d == '0 && vel_y_d == '0) begin
								phase_d = ST_STEADY;
							end else begin
								vel_x_d = div4(vel_x_d);
								vel_y_d = div4(vel_y_d);
								phase_d = ST_AUTO;
							end
						end
						ST_STOP: begin
							res_d.accepted = 1'b1;
							phase_d  = ST_STEADY;
							base_x_d = in_item_s1.cur_off_x;
							base_y_d = in_item_s1.cur_off_y;
						end
						default: ;
					endcase
				end
			end
			MODE_MOVE: begin
				if (in_item_s1.left_button) begin
					if (phase_q == ST_PRESSED || phase_q == ST_STOP) begin
						if (beyond) begin
							res_d.accepted = 1'b1;
							phase_d   = ST_MANUAL;
							stamp_d   = in_item_s1.now_ms;
							last_x_d  = '0;
							last_y_d  = '0;
							press_x_d = in_item_s1.pos_x;
							press_y_d = in_item_s1.pos_y;
						end
					end else if (phase_q == ST_MANUAL) begin
						res_d.accepted = 1'b1;
						res_d.set_offset_valid = 1'b1;
						res_d.new_off_x = drag_nx;
						res_d.new_off_y = drag_ny;
						if (take_smp) begin
							stamp_d  = in_item_s1.now_ms;
							last_x_d = dx_w;
							last_y_d = dy_w;
							vel_x_d  = smp_vx;
							vel_y_d  = smp_vy;
						end
					end
				end
			end
			MODE_TICK: begin
				if (phase_q == ST_AUTO) begin
					res_d.accepted = 1'b1;
					res_d.set_offset_valid = 1'b1;
					res_d.new_off_x = tick_nx;
					res_d.new_off_y = tick_ny;
					vel_x_d  = dec_vx;
					vel_y_d  = dec_vy;
					base_x_d = tick_nx;
					base_y_d = tick_ny;
					if (dec_vx == '0 && dec_vy == '0) begin
						phase_d = ST_STEADY;
					end
				end
			end
			default: ;
		endcase

		res_d.ticker_run    = (phase_d == ST_AUTO);
		res_d.gesture_state = phase_d;
	end

	// gesture state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ST_STEADY;
			press_x_q   <= '0;
			press_y_q   <= '0;
			base_x_q    <= '0;
			base_y_q    <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			stamp_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid_s1;
			if (in_valid_s1) begin
				phase_q   <= phase_d;
				press_x_q <= press_x_d;
				press_y_q <= press_y_d;
				base_x_q  <= base_x_d;
				base_y_q  <= base_y_d;
				last_x_q  <= last_x_d;
				last_y_q  <= last_y_d;
				vel_x_q   <= vel_x_d;
				vel_y_q   <= vel_y_d;
				stamp_q   <= stamp_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid_s1) begin
			out_item_q <= res_d;
		end
	end

	// the reported state matches the machine after the item
	a_state_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && in_valid_s1) |=> (out_item_q.gesture_state == phase_q))
		else $error("reported gesture state differs from machine state");

	// the ticker runs exactly in auto scroll
	a_ticker_auto: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.ticker_run == (out_item_q.gesture_state == ST_AUTO)))
		else $error("ticker_run disagrees with gesture state");

	// an ignored item requests nothing
	a_ignored_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_item_q.accepted) |->
		(!out_item_q.set_offset_valid && !out_item_q.replay_click))
		else $error("ignored item produced a request");

	// a click replay only ends a press and lands in steady
	a_replay_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.replay_click) |->
		(out_item_q.gesture_state == ST_STEADY && click_fwd_en_q))
		else $error("click replay outside a plain press and release");

	// the machine only moves while an item is taken into the result register
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && in_valid_s1) |=> $stable(phase_q))
		else $error("gesture state changed with no item");

endmodule

### tb/tb_kinetic_scroll_gesture_fsm.sv
// testbench for the kinetic scroll gesture machine: directed and random pointer items checked against a predictor
module tb_kinetic_scroll_gesture_fsm;
	timeunit 1ns;
	timeprecision 1ps;

	import ksg_pkg::*;

	typedef enum logic [2:0] {
		G_STEADY  = 3'd0,
		G_PRESSED = 3'd1,
		G_MANUAL  = 3'd2,
		G_AUTO    = 3'd3,
		G_STOP    = 3'd4
	} gesture_phase_t;

	localparam int MAX_SPEED      = 64;
	localparam int VEL_HI         = 131071;
	localparam int VEL_LO         = -131072;
	localparam int PHASE_TARGET   = 340;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	ksg_in_t               in_item = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	ksg_out_t              out_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the registers
	logic [THR_W-1:0] thr_cfg = DRAG_THRESHOLD_RST;
	logic [IVL_W-1:0] ivl_cfg = SPEED_INTERVAL_RST;
	bit               click_cfg = 1'b0;

	// predictor copy of the gesture state
	gesture_phase_t           gphase = G_STEADY;
	logic signed [POS_W-1:0]  press_x = '0;
	logic signed [POS_W-1:0]  press_y = '0;
	logic signed [OFF_W-1:0]  base_x = '0;
	logic signed [OFF_W-1:0]  base_y = '0;
	int                       drag_x = 0;
	int                       drag_y = 0;
	int                       vel_x = 0;
	int                       vel_y = 0;
	logic [TIME_W-1:0]        sample_stamp = '0;

	ksg_in_t  pending_events[$];
	ksg_out_t awaited_results[$];
	ksg_out_t predicted_result;
	ksg_out_t oldest_result;

	int send_idle_pct = 18;
	int recv_stall_pct = 63;
	int taken_in_phase = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	kinetic_scroll_gesture_fsm #(
		.MAX_SPEED(MAX_SPEED)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// saturate a sampled speed to 18 bits signed
	function automatic int clamp_speed(longint v);
		if (v > VEL_HI) begin
			return VEL_HI;
		end
		if (v < VEL_LO) begin
			return VEL_LO;
		end
		return int'(v);
	endfunction

	// clamp to max speed, then one step toward zero
	function automatic int decay_speed(int v);
		int c;
		c = v;
		if (c > MAX_SPEED) begin
			c = MAX_SPEED;
		end
		if (c < -MAX_SPEED) begin
			c = -MAX_SPEED;
		end
		if (c > 0) begin
			return c - 1;
		end
		if (c < 0) begin
			return c + 1;
		end
		return 0;
	endfunction

	// speed sample once the interval has passed, modulo 2^32
	function automatic void take_speed_sample(int dx, int dy, logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] gap;
		gap = now - sample_stamp;
		if (gap > TIME_W'(ivl_cfg)) begin
			sample_stamp = now;
			vel_x = clamp_speed(longint'(dx) - drag_x);
			vel_y = clamp_speed(longint'(dy) - drag_y);
			drag_x = dx;
			drag_y = dy;
		end
	endfunction

	// one pointer item through the gesture machine
	function automatic ksg_out_t gesture_step(ksg_in_t ev);
		ksg_out_t r;
		int dx;
		int dy;
		int th;
		r = '0;
		th = int'(thr_cfg);
		dx = int'($signed(ev.pos_x)) - int'(press_x);
		dy = int'($signed(ev.pos_y)) - int'(press_y);
		case (ev.mode)
			MODE_PRESS: begin
				if (ev.left_button && (gphase == G_STEADY || gphase == G_AUTO)) begin
					r.accepted = 1'b1;
					if (gphase == G_AUTO) begin
						vel_x = 0;
						vel_y = 0;
						gphase = G_STOP;
					end else begin
						gphase = G_PRESSED;
					end
					press_x = ev.pos_x;
					press_y = ev.pos_y;
					base_x = ev.cur_off_x;
					base_y = ev.cur_off_y;
				end
			end
			MODE_RELEASE: begin
				if (ev.left_button) begin
					case (gphase)
						G_PRESSED: begin
							r.accepted = 1'b1;
							gphase = G_STEADY;
							if (click_cfg) begin
								r.replay_click = 1'b1;
								r.click_x = press_x;
								r.click_y = press_y;
							end
						end
						G_MANUAL: begin
							r.accepted = 1'b1;
							take_speed_sample(dx, dy, ev.now_ms);
							base_x = ev.cur_off_x;
							base_y = ev.cur_off_y;
							press_x = ev.pos_x;
							press_y = ev.pos_y;
							if (vel_x == 0 && vel_y == 0) begin
								gphase = G_STEADY;
							end else begin
								vel_x = vel_x / 4;
								vel_y = vel_y / 4;
								gphase = G_AUTO;
							end
						end
						G_STOP: begin
							r.accepted = 1'b1;
							gphase = G_STEADY;
							base_x = ev.cur_off_x;
							base_y = ev.cur_off_y;
						end
						default: begin
						end
					endcase
				end
			end
			MODE_MOVE: begin
				if (ev.left_button) begin
					if (gphase == G_PRESSED || gphase == G_STOP) begin
						// drag past the threshold on either axis starts manual scrolling
						if (dx > th || dx < -th || dy > th || dy < -th) begin
							sample_stamp = ev.now_ms;
							gphase = G_MANUAL;
							drag_x = 0;
							drag_y = 0;
							press_x = ev.pos_x;
							press_y = ev.pos_y;
							r.accepted = 1'b1;
						end
					end else if (gphase == G_MANUAL) begin
						r.accepted = 1'b1;
						r.set_offset_valid = 1'b1;
						r.new_off_x = OFF_W'(int'(base_x) - dx);
						r.new_off_y = OFF_W'(int'(base_y) - dy);
						take_speed_sample(dx, dy, ev.now_ms);
					end
				end
			end
			MODE_TICK: begin
				if (gphase == G_AUTO) begin
					r.accepted = 1'b1;
					vel_x = decay_speed(vel_x);
					vel_y = decay_speed(vel_y);
					r.set_offset_valid = 1'b1;
					r.new_off_x = OFF_W'(int'(base_x) - vel_x);
					r.new_off_y = OFF_W'(int'(base_y) - vel_y);
					base_x = r.new_off_x;
					base_y = r.new_off_y;
					if (vel_x == 0 && vel_y == 0) begin
						gphase = G_STEADY;
					end
				end
			end
			default: begin
			end
		endcase
		r.ticker_run = (gphase == G_AUTO);
		r.gesture_state = gphase;
		return r;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic queue_event(logic [1:0] m, bit lb, int px, int py, int cx, int cy,
			logic [TIME_W-1:0] t);
		ksg_in_t ev;
		ev.mode = m;
		ev.left_button = lb;
		ev.pos_x = POS_W'(px);
		ev.pos_y = POS_W'(py);
		ev.cur_off_x = OFF_W'(cx);
		ev.cur_off_y = OFF_W'(cy);
		ev.now_ms = t;
		pending_events.push_back(ev);
	endtask

	// register write while the block is idle
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_DRAG_THRESHOLD: thr_cfg = data[THR_W-1:0];
			CFG_SPEED_INTERVAL: ivl_cfg = data[IVL_W-1:0];
			CFG_CLICK_FORWARD_EN: click_cfg = data[0];
			default: begin
			end
		endcase
	endtask

	// driver: predict each taken item, then offer the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predicted_result = gesture_step(in_item);
				taken_in_phase++;
				awaited_results.push_back(predicted_result);
			end
			if (!in_valid || !in_stall) begin
				if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_item <= pending_events.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// monitor: compare each result item with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$error("result item with no prediction waiting");
				mismatches++;
			end else begin
				oldest_result = awaited_results.pop_front();
				check_field("accepted", oldest_result.accepted, out_item.accepted);
				check_field("set_offset_valid", oldest_result.set_offset_valid,
					out_item.set_offset_valid);
				check_field("new_off_x", oldest_result.new_off_x, out_item.new_off_x);
				check_field("new_off_y", oldest_result.new_off_y, out_item.new_off_y);
				check_field("replay_click", oldest_result.replay_click, out_item.replay_click);
				check_field("click_x", oldest_result.click_x, out_item.click_x);
				check_field("click_y", oldest_result.click_y, out_item.click_y);
				check_field("ticker_run", oldest_result.ticker_run, out_item.ticker_run);
				check_field("gesture_state", oldest_result.gesture_state,
					out_item.gesture_state);
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// stimulus and phase sequencing
	initial begin
		int ph;
		int gx;
		int gy;
		int off_x;
		int off_y;
		int n;
		int k;
		int d;
		int gap_max;
		logic [TIME_W-1:0] clk_ms;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: ignored events, threshold edge, wrap of time and offsets, flick and stop
		queue_event(MODE_TICK, 1, 0, 0, 0, 0, 10);
		queue_event(MODE_PRESS, 0, 5, 5, 1, 1, 20);
		queue_event(MODE_RELEASE, 1, 5, 5, 1, 1, 30);
		queue_event(MODE_MOVE, 1, 50, 50, 1, 1, 40);
		queue_event(MODE_PRESS, 1, -32768, 32767, -8388608, 8388607, 32'hFFFF_FFF0);
		queue_event(MODE_PRESS, 1, 0, 0, 0, 0, 32'hFFFF_FFF1);
		queue_event(MODE_MOVE, 0, 0, 0, 0, 0, 32'hFFFF_FFF2);
		queue_event(MODE_MOVE, 1, -32758, 32767, 0, 0, 32'hFFFF_FFF3);
		queue_event(MODE_MOVE, 1, -32757, 32767, 0, 0, 32'hFFFF_FFF4);
		queue_event(MODE_PRESS, 1, 3, 3, 0, 0, 32'hFFFF_FFF5);
		queue_event(MODE_MOVE, 1, 32767, -32768, 0, 0, 32'h0000_0060);
		queue_event(MODE_RELEASE, 1, 32767, -32768, 0, 0, 32'h0000_0070);
		queue_event(MODE_TICK, 0, 0, 0, 0, 0, 32'h0000_0071);
		queue_event(MODE_PRESS, 1, 10, 10, 100, 100, 32'h0000_0072);
		queue_event(MODE_RELEASE, 1, 10, 10, 100, 100, 32'h0000_0073);
		queue_event(MODE_PRESS, 1, 0, 0, 0, 0, 500);
		queue_event(MODE_RELEASE, 1, 0, 0, 0, 0, 501);
		queue_event(MODE_PRESS, 1, 100, 100, 7, 7, 1000);
		queue_event(MODE_MOVE, 1, 200, 100, 7, 7, 1001);
		queue_event(MODE_RELEASE, 1, 200, 100, 7, 7, 1002);
		// small speed that divides down to zero
		queue_event(MODE_PRESS, 1, 0, 0, 40, 40, 2000);
		queue_event(MODE_MOVE, 1, 20, 0, 40, 40, 2001);
		queue_event(MODE_MOVE, 1, 23, 0, 40, 40, 2200);
		queue_event(MODE_RELEASE, 1, 23, 0, 40, 40, 2201);
		queue_event(MODE_MOVE, 1, 50, 50, 40, 40, 2202);
		queue_event(MODE_TICK, 1, 0, 0, 40, 40, 2203);

		clk_ms = $urandom;
		off_x = int'($urandom_range(2000000)) - 1000000;
		off_y = int'($urandom_range(2000000)) - 1000000;

		for (ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 18 : (ph < 4) ? 63 : 0;
			recv_stall_pct = (ph < 2) ? 63 : (ph < 4) ? 18 : 0;
			case (ph)
				1: begin
					write_register(CFG_DRAG_THRESHOLD, 16'd0);
					write_register(CFG_SPEED_INTERVAL, 16'd0);
					write_register(CFG_CLICK_FORWARD_EN, 16'd1);
				end
				2: begin
					write_register(CFG_DRAG_THRESHOLD, 16'd1023);
					write_register(CFG_SPEED_INTERVAL, 16'hFFFF);
					write_register(CFG_CLICK_FORWARD_EN, 16'd0);
					write_register(CFG_UNUSED, CFG_DATA_W'($urandom));
				end
				3: begin
					write_register(CFG_DRAG_THRESHOLD, CFG_DATA_W'($urandom));
					write_register(CFG_SPEED_INTERVAL, CFG_DATA_W'($urandom_range(300)));
					write_register(CFG_CLICK_FORWARD_EN, CFG_DATA_W'($urandom_range(1)));
				end
				4: begin
					write_register(CFG_DRAG_THRESHOLD, 16'd3);
					write_register(CFG_SPEED_INTERVAL, 16'd20);
					write_register(CFG_CLICK_FORWARD_EN, 16'd1);
				end
				5: begin
					write_register(CFG_DRAG_THRESHOLD, CFG_DATA_W'($urandom_range(40)));
					write_register(CFG_SPEED_INTERVAL, CFG_DATA_W'($urandom_range(150)));
					write_register(CFG_CLICK_FORWARD_EN, CFG_DATA_W'($urandom_range(1)));
				end
				default: begin
				end
			endcase
			taken_in_phase = 0;

			// random gestures, topped up while the driver drains them
			while (taken_in_phase < PHASE_TARGET) begin
				if (pending_events.size() >= 16) begin
					@(posedge clk);
				end else if ($urandom_range(9) == 0) begin
					// noise: any event with any field values
					queue_event(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom,
						$urandom, $urandom, $urandom, $urandom);
				end else begin
					gap_max = int'(ivl_cfg) + int'(ivl_cfg) / 2 + 20;
					gx = ($urandom_range(4) == 0) ? int'($urandom)
						: int'($urandom_range(2000)) - 1000;
					gy = ($urandom_range(4) == 0) ? int'($urandom)
						: int'($urandom_range(2000)) - 1000;
					off_x += int'($urandom_range(4000)) - 2000;
					off_y += int'($urandom_range(4000)) - 2000;
					clk_ms += $urandom_range(gap_max);
					queue_event(MODE_PRESS, 1, gx, gy, off_x, off_y, clk_ms);
					if ($urandom_range(4) == 0) begin
						// click: release with no drag
						clk_ms += $urandom_range(gap_max);
						queue_event(MODE_RELEASE, 1, gx, gy, off_x, off_y, clk_ms);
					end else begin
						// first move lands just around the threshold
						d = int'(thr_cfg) + int'($urandom_range(30)) - 3;
						if ($urandom_range(1)) begin
							d = -d;
						end
						if ($urandom_range(1)) begin
							gx += d;
						end else begin
							gy += d;
						end
						clk_ms += $urandom_range(gap_max);
						queue_event(MODE_MOVE, 1, gx, gy, off_x, off_y, clk_ms);
						n = $urandom_range(1, 8);
						repeat (n) begin
							gx += int'($urandom_range(120)) - 60;
							gy += int'($urandom_range(120)) - 60;
							clk_ms += $urandom_range(gap_max);
							queue_event(MODE_MOVE, $urandom_range(9) != 0, gx, gy, off_x, off_y,
								clk_ms);
						end
						clk_ms += $urandom_range(gap_max);
						queue_event(MODE_RELEASE, $urandom_range(9) != 0, gx, gy, off_x, off_y,
							clk_ms);
						// coasting ticks, sometimes caught by a new press
						n = $urandom_range(70);
						k = 0;
						while (k < n) begin
							clk_ms += $urandom_range(1, 20);
							if ($urandom_range(19) == 0) begin
								queue_event(MODE_PRESS, 1, gx, gy, off_x, off_y, clk_ms);
								if ($urandom_range(1)) begin
									gx += int'(thr_cfg) + 1 + int'($urandom_range(20));
									clk_ms += $urandom_range(gap_max);
									queue_event(MODE_MOVE, 1, gx, gy, off_x, off_y, clk_ms);
								end
								clk_ms += $urandom_range(gap_max);
								queue_event(MODE_RELEASE, 1, gx, gy, off_x, off_y, clk_ms);
								k = n;
							end else begin
								queue_event(MODE_TICK, 1'($urandom_range(1)), gx, gy, off_x,
									off_y, clk_ms);
								k++;
							end
						end
					end
				end
			end

			// drain before touching the registers again
			while (pending_events.size() != 0 || in_valid || awaited_results.size() != 0) begin
				@(posedge clk);
			end
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
